// File: sv/mse_pkg.sv
// Package for the merge sort engine: sizes, item structs and the command
// struct passed from the front end to the sorter. No dependencies.
`timescale 1ns / 1ps

package mse_pkg;

    localparam int MAX_LEN = 64;                  // store depth
    localparam int AW      = $clog2(MAX_LEN);     // store address width
    localparam int CW      = $clog2(MAX_LEN + 1); // element count width
    localparam int QDEPTH  = 4;                   // command queue depth
    localparam int QAW     = $clog2(QDEPTH);

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] sorted_value;
        logic       end_of_run;
        logic       overflow;
    } out_item_t;

    // One classified input item: optional store write, optional end of list.
    typedef struct packed {
        logic          wr;     // store value at addr
        logic          fin;    // list ends here, sort and emit
        logic [AW-1:0] addr;
        logic [7:0]    value;
        logic [CW-1:0] n;      // list length, valid with fin
        logic          ovf;    // list was cut, valid with fin
    } cmd_t;

endpackage

// File: sv/merge_sort_engine.sv
// Top level of the merge sort engine: front end, command queue and sorter.
// Depends on mse_pkg, mse_front, mse_fifo and mse_back.
//
//  Channel  Handshake       Payload
//  input    push / full     entry  (in_item_t: value, last)
//  output   pop / empty     result (out_item_t: sorted_value, end_of_run, overflow)
//
// Loading takes one item per cycle until the command queue fills.
// A list of N items sorts in ceil(log2 N) passes. A pass sets up each merged
// block, then runs the sorter's read/merge loop, one compare and one element
// per loop. Each result is then read from the store and loaded into the output.
// Reset is asynchronous and empties the queue, the counts and the output.
// Either side may stall any time; the queue keeps loading while sorting.
`timescale 1ns / 1ps

module merge_sort_engine
    import mse_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  in_item_t  entry,
    output logic      full,
    output logic      empty,
    input  logic      pop,
    output out_item_t result
);

    cmd_t front_cmd, queue_cmd;
    logic cmd_push, q_full, cmd_valid, cmd_pop;

    mse_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .entry    (entry),
        .full     (full),
        .q_full   (q_full),
        .cmd_push (cmd_push),
        .cmd      (front_cmd)
    );

    mse_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cmd_push),
        .wr_data  (front_cmd),
        .q_full   (q_full),
        .rd_en    (cmd_pop),
        .rd_data  (queue_cmd),
        .rd_valid (cmd_valid)
    );

    mse_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (queue_cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .result    (result),
        .empty     (empty),
        .pop       (pop)
    );

    // Front end never enqueues into a full queue
    assert property (@(posedge clk) disable iff (!rst_n) cmd_push |-> !q_full)
        else $error("command pushed into full queue");

    // Sorter only takes a command that is there
    assert property (@(posedge clk) disable iff (!rst_n) cmd_pop |-> cmd_valid)
        else $error("command popped from empty queue");

    // A list end with a store write never reports a zero list length
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_push && front_cmd.fin && front_cmd.wr) |-> (front_cmd.n != '0))
        else $error("list end with zero length");

endmodule

// File: sv/mse_front.sv
// Front end of the merge sort engine: accepts input items, counts the list
// and turns each stored item and each list end into a command for the sorter. Depends on mse_pkg.
`timescale 1ns / 1ps

module mse_front
    import mse_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  in_item_t entry,
    output logic     full,
    input  logic     q_full,
    output logic     cmd_push,
    output cmd_t     cmd
);

    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic          accept;
    logic          room;

    assign full   = q_full;
    assign accept = push && !q_full;
    assign room   = (count_reg < CW'(MAX_LEN));

    // Classify: store while there is room, otherwise mark overflow
    always_comb
    begin
        count_next = room ? count_reg + CW'(1) : count_reg;
        ovf_next   = ovf_reg || !room;
        cmd.wr     = room;
        cmd.fin    = entry.last;
        cmd.addr   = count_reg[AW-1:0];
        cmd.value  = entry.value;
        cmd.n      = count_next;
        cmd.ovf    = ovf_next;
    end

    // Dropped non-final items need no command
    assign cmd_push = accept && (room || entry.last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (accept)
        begin
            if (entry.last)
            begin
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            else
            begin
                count_reg <= count_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

endmodule

// File: sv/mse_fifo.sv
// Short command queue between the front end and the sorter.
// Depends on mse_pkg.
`timescale 1ns / 1ps

module mse_fifo
    import mse_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_data,
    output logic q_full,
    input  logic rd_en,
    output cmd_t rd_data,
    output logic rd_valid
);

    cmd_t           slot_reg [QDEPTH];
    logic [QAW-1:0] wptr_reg, rptr_reg;
    logic [QAW:0]   cnt_reg;
    logic           do_wr, do_rd;

    assign q_full   = (cnt_reg == (QAW+1)'(QDEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = slot_reg[rptr_reg];
    assign do_wr    = wr_en && !q_full;
    assign do_rd    = rd_en && rd_valid;

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wptr_reg] <= wr_data;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wptr_reg <= wptr_reg + QAW'(1);
            if (do_rd)
                rptr_reg <= rptr_reg + QAW'(1);
            unique case ({do_wr, do_rd})
                2'b10:   cnt_reg <= cnt_reg + (QAW+1)'(1);
                2'b01:   cnt_reg <= cnt_reg - (QAW+1)'(1);
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

// File: sv/mse_back.sv
// Back end of the merge sort engine: element store, bottom-up merge passes
// ping-ponging between two banks, and the result register. Depends on mse_pkg.
`timescale 1ns / 1ps

module mse_back
    import mse_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cmd_t      cmd,
    input  logic      cmd_valid,
    output logic      cmd_pop,
    output out_item_t result,
    output logic      empty,
    input  logic      pop
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_BLOCK,
        S_FETCH,
        S_MERGE,
        S_OREAD,
        S_OPUSH
    } state_t;

    state_t        state_reg;
    logic [CW-1:0] n_reg, w_reg, lo_reg, mid_reg, hi_reg, a_reg, b_reg, k_reg;
    logic          ovf_reg, src_reg;
    out_item_t     out_reg;
    logic          out_valid_reg;

    logic [7:0]    bank0_mem [MAX_LEN];
    logic [7:0]    bank1_mem [MAX_LEN];
    logic [7:0]    rd0a_reg, rd0b_reg, rd1a_reg, rd1b_reg;

    logic [7:0]    head_a, head_b, pick;
    logic          a_done, b_done, take_b;
    logic [CW:0]   lo_w, w_dbl, lo_2w;
    logic [CW-1:0] blk_mid, blk_hi;
    logic          store_we, merge_we, out_load;

    assign result  = out_reg;
    assign empty   = !out_valid_reg;
    assign cmd_pop = (state_reg == S_IDLE) && cmd_valid;

    // Merge decision; ties take the right run
    always_comb
    begin
        head_a = src_reg ? rd1a_reg : rd0a_reg;
        head_b = src_reg ? rd1b_reg : rd0b_reg;
        a_done = (a_reg >= mid_reg);
        b_done = (b_reg >= hi_reg);
        take_b = a_done || (!b_done && !(head_a < head_b));
        pick   = take_b ? head_b : head_a;
    end

    // Block bounds for the current pass
    always_comb
    begin
        w_dbl   = {w_reg, 1'b0};
        lo_w    = {1'b0, lo_reg} + {1'b0, w_reg};
        lo_2w   = {1'b0, lo_reg} + w_dbl;
        blk_mid = (lo_w  > {1'b0, n_reg}) ? n_reg : lo_w[CW-1:0];
        blk_hi  = (lo_2w > {1'b0, n_reg}) ? n_reg : lo_2w[CW-1:0];
    end

    assign store_we = cmd_pop && cmd.wr;
    assign merge_we = (state_reg == S_MERGE);
    assign out_load = (state_reg == S_OPUSH) && (!out_valid_reg || pop);

    // Bank 0: loaded from commands, merge target on odd passes
    always_ff @(posedge clk)
    begin
        if (store_we)
            bank0_mem[cmd.addr] <= cmd.value;
        else if (merge_we && src_reg)
            bank0_mem[k_reg[AW-1:0]] <= pick;
        rd0a_reg <= bank0_mem[a_reg[AW-1:0]];
        rd0b_reg <= bank0_mem[b_reg[AW-1:0]];
    end

    // Bank 1: merge target on even passes
    always_ff @(posedge clk)
    begin
        if (merge_we && !src_reg)
            bank1_mem[k_reg[AW-1:0]] <= pick;
        rd1a_reg <= bank1_mem[a_reg[AW-1:0]];
        rd1b_reg <= bank1_mem[b_reg[AW-1:0]];
    end

    // Sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            n_reg         <= '0;
            w_reg         <= '0;
            lo_reg        <= '0;
            mid_reg       <= '0;
            hi_reg        <= '0;
            a_reg         <= '0;
            b_reg         <= '0;
            k_reg         <= '0;
            ovf_reg       <= 1'b0;
            src_reg       <= 1'b0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // a new result replaces a popped one in the same cycle
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (pop && out_valid_reg)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid && cmd.fin)
                    begin
                        n_reg   <= cmd.n;
                        ovf_reg <= cmd.ovf;
                        src_reg <= 1'b0;
                        w_reg   <= CW'(1);
                        lo_reg  <= '0;
                        a_reg   <= '0;
                        if (cmd.n <= CW'(1))
                            state_reg <= S_OREAD;
                        else
                            state_reg <= S_BLOCK;
                    end
                end

                S_BLOCK:
                begin
                    mid_reg   <= blk_mid;
                    hi_reg    <= blk_hi;
                    a_reg     <= lo_reg;
                    b_reg     <= blk_mid;
                    k_reg     <= lo_reg;
                    state_reg <= S_FETCH;
                end

                S_FETCH:
                    state_reg <= S_MERGE;

                S_MERGE:
                begin
                    k_reg <= k_reg + CW'(1);
                    if (take_b)
                        b_reg <= b_reg + CW'(1);
                    else
                        a_reg <= a_reg + CW'(1);

                    if (k_reg + CW'(1) == hi_reg)
                    begin
                        if (lo_2w >= {1'b0, n_reg})
                        begin
                            // pass done
                            w_reg   <= w_dbl[CW-1:0];
                            src_reg <= !src_reg;
                            lo_reg  <= '0;
                            if (w_dbl >= {1'b0, n_reg})
                            begin
                                a_reg     <= '0;
                                state_reg <= S_OREAD;
                            end
                            else
                                state_reg <= S_BLOCK;
                        end
                        else
                        begin
                            lo_reg    <= lo_2w[CW-1:0];
                            state_reg <= S_BLOCK;
                        end
                    end
                    else
                        state_reg <= S_FETCH;
                end

                S_OREAD:
                    state_reg <= S_OPUSH;

                S_OPUSH:
                begin
                    if (out_load)
                    begin
                        out_reg.sorted_value <= head_a;
                        out_reg.end_of_run   <= (a_reg + CW'(1) == n_reg);
                        out_reg.overflow     <= ovf_reg;
                        a_reg                <= a_reg + CW'(1);
                        if (a_reg + CW'(1) == n_reg)
                            state_reg <= S_IDLE;
                        else
                            state_reg <= S_OREAD;
                    end
                end

                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
